// ===== rtl/core/number_constant_pool_assert.svh =====
// assertion macros for the constant pool
`ifndef NUMBER_CONSTANT_POOL_ASSERT_SVH
`define NUMBER_CONSTANT_POOL_ASSERT_SVH

// implication checked every clock outside reset
`define NCP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define NCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ncp_pkg.sv =====
// ----------------------------------------------------------------------------
// ncp_pkg
// shared types and constants for the constant pool
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ncp_pkg;

    localparam logic [63:0] ABS_MASK = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INF_BITS = 64'h7FF0_0000_0000_0000;
    localparam int unsigned CAP_W = 9;
    localparam int unsigned IDX_W = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } t_state;

    function automatic logic is_nan(input logic [63:0] b);
        is_nan = (b & ABS_MASK) > INF_BITS;
    endfunction

    function automatic logic ieee_eq(input logic [63:0] a, input logic [63:0] b);
        logic za;
        logic zb;
        za = (a & ABS_MASK) == 64'd0;
        zb = (b & ABS_MASK) == 64'd0;
        if (is_nan(a) || is_nan(b)) begin
            ieee_eq = 1'b0;
        end else if (za && zb) begin
            ieee_eq = 1'b1;
        end else begin
            ieee_eq = (a == b);
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ncp_store.sv =====
// ----------------------------------------------------------------------------
// ncp_store
// entry memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ncp_store #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [63:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [63:0]   o_rdata
);
    logic [63:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/number_constant_pool.sv =====
// ----------------------------------------------------------------------------
// number_constant_pool
// deduplicating pool of double constants with linear search
// ----------------------------------------------------------------------------
// Usage: pulse i_start with i_value_bits while o_busy is low. The block reads
// stored entries from index 0 upward, one per cycle from the entry memory,
// comparing under IEEE equality (+0 equals -0, NaN never matches). On a hit
// the index is returned; otherwise the value is appended if the count is
// below capacity (limited to DEPTH), or o_full_res is set.
// The result appears for one cycle with o_valid; the receiver cannot stall.
// On a miss every stored entry is read from the entry memory before the
// result is given; a hit ends the search at the matching entry. The next
// start is taken the cycle after o_valid.
// Configuration: i_cfg_we writes capacity (9 bits, reset 256); the user must
// write it only while idle, which the block itself does not enforce. Reset
// empties the pool (count to zero); entry memory needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module number_constant_pool #(
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    output logic                            o_busy,
    input  wire logic [63:0]                i_value_bits,
    input  wire logic                       i_cfg_we,
    input  wire logic [ncp_pkg::CAP_W-1:0]  i_cfg_wdata,
    output logic                            o_valid,
    output logic [ncp_pkg::IDX_W-1:0]       o_entry_index,
    output logic                            o_full_res,
    output logic                            o_added
);
    import ncp_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_ptr;
    logic          r_rd_vld;
    logic [CW-1:0] r_rd_idx;
    logic [63:0]   r_value;
    logic [CAP_W-1:0] r_cap;
    logic [63:0]   w_rdata;
    logic [CW-1:0] w_limit;
    logic          w_hit;
    logic          w_issue;
    logic          w_room;
    logic          w_we;
    logic          w_finish;

    always_comb begin
        if (32'(r_cap) >= 32'(DEPTH)) begin
            w_limit = CW'(DEPTH);
        end else begin
            w_limit = CW'(r_cap);
        end
    end

    assign w_hit    = r_rd_vld && ieee_eq(w_rdata, r_value);
    assign w_issue  = (r_state == ST_SEARCH) && (r_ptr < r_count) && !w_hit;
    assign w_room   = r_count < w_limit;
    assign w_finish = (r_state == ST_SEARCH) && (w_hit || (!w_issue && !r_rd_vld));
    assign w_we     = w_finish && !w_hit && w_room;

    ncp_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_value),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_start) n_state = ST_SEARCH;
            ST_SEARCH: if (w_finish) n_state = ST_DONE;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy = (r_state != ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
            r_cap    <= CAP_W'(256);
            o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= w_finish;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (r_state == ST_IDLE) begin
                r_ptr    <= '0;
                r_rd_vld <= 1'b0;
            end else begin
                r_rd_vld <= w_issue;
                if (w_issue) begin
                    r_ptr <= r_ptr + 1'b1;
                end
            end
            if (w_we) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_value <= i_value_bits;
        end
        if (r_state == ST_SEARCH) begin
            r_rd_idx <= r_ptr;
        end
        if (w_finish) begin
            if (w_hit) begin
                o_entry_index <= IDX_W'(r_rd_idx);
                o_full_res    <= 1'b0;
                o_added       <= 1'b0;
            end else if (w_room) begin
                o_entry_index <= IDX_W'(r_count);
                o_full_res    <= 1'b0;
                o_added       <= 1'b1;
            end else begin
                o_entry_index <= '0;
                o_full_res    <= 1'b1;
                o_added       <= 1'b0;
            end
        end
    end

`include "number_constant_pool_assert.svh"
    `NCP_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CW'(DEPTH), "count exceeds depth")
    `NCP_ASSERT_IMPL(a_one_flag, o_valid, !(o_full_res && o_added), "full and added together")
    `NCP_ASSERT_NEXT(a_we_counts, w_we, r_count == $past(r_count) + 1'b1, "append not counted")
    `NCP_ASSERT_IMPL(a_valid_busy, o_valid, r_state == ST_DONE, "result outside done")
endmodule
`default_nettype wire
